FILE: hw/rtl/ray_rectangle_light_hit_assert.svh
// Assertion macros for the rectangle light hit block.
// Clocked on clk, disabled while arst_n is low; used by the top level only.
`ifndef RAY_RECTANGLE_LIGHT_HIT_ASSERT_SVH
`define RAY_RECTANGLE_LIGHT_HIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RRLH_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rrlh assertion failed");
`define RRLH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rrlh assertion failed");
`else
`define RRLH_ASSERT_IMPL(lbl, ante, cons)
`define RRLH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/rrlh_pkg.sv
// Shared widths, register codes and types of the rectangle light hit block.
// No dependencies.
package rrlh_pkg;
	localparam int CW   = 20;             // coordinate width
	localparam int FB   = 8;              // fraction bits
	localparam int WW   = CW + 1;         // origin minus centre
	localparam int PW   = WW + CW + 2;    // plane dot products
	localparam int MW   = PW - 1;         // magnitude of a positive dot product
	localparam int NW   = MW + FB;        // dividend
	localparam int QB   = CW + FB + 2;    // quotient bits
	localparam int TW   = CW + FB + 1;    // t up to and including the cap
	localparam int PRW  = CW + TW + 1;    // direction times t
	localparam int PTW  = CW + TW - FB;   // unsaturated hit point
	localparam int QW   = PTW + 1;        // hit point minus centre
	localparam int SW   = QW + CW + 2;    // edge projections
	localparam int UUW  = 2 * CW + 2;     // squared edge length
	localparam int QD   = 4;              // queue depth
	localparam int QAW  = $clog2(QD);
	localparam int RW   = 64;             // APB data width
	localparam int AW   = 6;              // APB address width
	localparam int RIW  = AW - 3;         // register index width

	localparam logic [RIW-1:0] REG_KIND   = RIW'(0);
	localparam logic [RIW-1:0] REG_CENTER = RIW'(1);
	localparam logic [RIW-1:0] REG_NORMAL = RIW'(2);
	localparam logic [RIW-1:0] REG_EDGE_U = RIW'(3);
	localparam logic [RIW-1:0] REG_EDGE_V = RIW'(4);

	localparam logic [1:0] LIGHT_AREA = 2'd2;

	typedef logic [2:0][CW-1:0] vec3_t;

	typedef struct packed {
		logic [1:0] kind;
		vec3_t      c;
		vec3_t      n;
		vec3_t      u;
		vec3_t      v;
	} lcfg_t;

	typedef struct packed {
		logic          ok;
		logic [MW-1:0] num;
		logic [MW-1:0] den;
		vec3_t         o;
		vec3_t         d;
	} qent_t;

	typedef struct packed {
		logic  ok;
		vec3_t o;
		vec3_t d;
	} tag_t;
endpackage

FILE: hw/rtl/rrlh_ray_if.sv
// Ray request channel: valid/ready handshake with origin and direction.
// Depends on rrlh_pkg.
interface rrlh_ray_if import rrlh_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] origin_x;
	logic signed [CW-1:0] origin_y;
	logic signed [CW-1:0] origin_z;
	logic signed [CW-1:0] dir_x;
	logic signed [CW-1:0] dir_y;
	logic signed [CW-1:0] dir_z;

	modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

FILE: hw/rtl/rrlh_hit_if.sv
// Hit result channel: valid/ready handshake with hit flag, t and hit point.
// Depends on rrlh_pkg.
interface rrlh_hit_if import rrlh_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [CW-1:0]        distance_t;
	logic signed [CW-1:0] hit_x;
	logic signed [CW-1:0] hit_y;
	logic signed [CW-1:0] hit_z;

	modport source(output valid, hit, distance_t, hit_x, hit_y, hit_z, input ready);
	modport sink(input valid, hit, distance_t, hit_x, hit_y, hit_z, output ready);
endinterface

FILE: hw/rtl/rrlh_front.sv
// Front end: accepts rays, forms the plane dot products and classifies them.
// Depends on rrlh_pkg and rrlh_ray_if.
module rrlh_front import rrlh_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	rrlh_ray_if.sink ray,
	input  lcfg_t cfg,
	input  logic  q_full,
	output logic  q_push,
	output qent_t q_data
);
	logic                    en;
	logic                    v_s1, v_s2, v_s3;
	logic                    kind_s1, kind_s2, ok_s3;
	vec3_t                   o_s1, d_s1, o_s2, d_s2, o_s3, d_s3;
	logic signed [WW-1:0]    w_s1 [3];
	logic signed [WW+CW-1:0] wn_s2 [3];
	logic signed [2*CW-1:0]  dn_s2 [3];
	logic [MW-1:0]           num_s3, den_s3;
	logic signed [PW-1:0]    psum, dsum;

	// hold the whole front while the queue cannot take the last stage
	assign en = !(v_s3 && q_full);
	assign ray.ready = en;
	assign q_push = v_s3 && !q_full;

	assign psum = PW'(wn_s2[0]) + PW'(wn_s2[1]) + PW'(wn_s2[2]);
	assign dsum = -(PW'(dn_s2[0]) + PW'(dn_s2[1]) + PW'(dn_s2[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= ray.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_s1    <= {ray.origin_z, ray.origin_y, ray.origin_x};
			d_s1    <= {ray.dir_z, ray.dir_y, ray.dir_x};
			w_s1[0] <= WW'(ray.origin_x) - WW'($signed(cfg.c[0]));
			w_s1[1] <= WW'(ray.origin_y) - WW'($signed(cfg.c[1]));
			w_s1[2] <= WW'(ray.origin_z) - WW'($signed(cfg.c[2]));
			kind_s1 <= (cfg.kind == LIGHT_AREA);
			o_s2    <= o_s1;
			d_s2    <= d_s1;
			kind_s2 <= kind_s1;
			for (int i = 0; i < 3; i++) begin
				wn_s2[i] <= w_s1[i] * $signed(cfg.n[i]);
				dn_s2[i] <= $signed(d_s1[i]) * $signed(cfg.n[i]);
			end
			o_s3   <= o_s2;
			d_s3   <= d_s2;
			// front-facing, not parallel, plane not behind the origin
			ok_s3  <= kind_s2 && (dsum > 0) && !psum[PW-1];
			num_s3 <= psum[MW-1:0];
			den_s3 <= dsum[MW-1:0];
		end
	end

	assign q_data = '{ok: ok_s3, num: num_s3, den: den_s3, o: o_s3, d: d_s3};
endmodule

FILE: hw/rtl/rrlh_fifo.sv
// Short queue between the front and back ends.
// Depends on rrlh_pkg.
module rrlh_fifo import rrlh_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t wdata,
	output logic  full,
	input  logic  pop,
	output qent_t rdata,
	output logic  empty
);
	qent_t          mem_q [QD];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;

	assign full  = (cnt_q == (QAW+1)'(QD));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end
endmodule

FILE: hw/rtl/rrlh_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side tag.
// Depends on rrlh_pkg.
module rrlh_div import rrlh_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [MW-1:0] num,
	input  logic [MW-1:0] den,
	input  tag_t          in_tag,
	output logic          out_valid,
	output logic [QB-1:0] quo,
	output tag_t          out_tag
);
	logic          vld_s [QB+1];
	logic [NW-1:0] rem_s [QB+1];
	logic [MW-1:0] den_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	tag_t          tag_s [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else if (en)
			vld_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {num, FB'(0)};
			den_s[0] <= den;
			quo_s[0] <= '0;
			tag_s[0] <= in_tag;
		end
	end

	for (genvar i = 0; i < QB; i++) begin : g_bit
		localparam int B = QB - 1 - i;
		logic [NW-1:0] hi;
		logic          ge;

		assign hi = rem_s[i] >> B;
		assign ge = (hi >= NW'(den_s[i]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i+1] <= 1'b0;
			else if (en)
				vld_s[i+1] <= vld_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? rem_s[i] - (NW'(den_s[i]) << B) : rem_s[i];
				den_s[i+1] <= den_s[i];
				quo_s[i+1] <= quo_s[i] | (QB'(ge) << B);
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign out_valid = vld_s[QB];
	assign quo       = quo_s[QB];
	assign out_tag   = tag_s[QB];
endmodule

FILE: hw/rtl/rrlh_back.sv
// Back end: divides for t, builds the hit point, tests the rectangle bounds.
// Depends on rrlh_pkg, rrlh_hit_if and rrlh_div.
module rrlh_back import rrlh_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  lcfg_t cfg,
	input  logic  q_empty,
	input  qent_t q_data,
	output logic  q_pop,
	rrlh_hit_if.source res
);
	localparam logic [QB-1:0] T_CAP = QB'(1) << (TW - 1);
	localparam logic signed [PTW-1:0] SMAX = PTW'((64'sd1 <<< (CW - 1)) - 1);
	localparam logic signed [PTW-1:0] SMIN = -PTW'(64'sd1 <<< (CW - 1));

	logic                     en;
	logic                     dv_valid;
	logic [QB-1:0]            dv_quo;
	tag_t                     dv_tag;
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                     ok_s1, ok_s2, ok_s3, ok_s4;
	logic [TW-1:0]            t_s1, t_s2, t_s3, t_s4;
	vec3_t                    o_s1;
	logic signed [PRW-1:0]    prod_s1 [3];
	logic signed [PTW-1:0]    p_c [3];
	logic signed [PTW-1:0]    p_s2 [3], p_s3 [3], p_s4 [3];
	logic signed [QW-1:0]     q_s2 [3];
	logic signed [QW+CW-1:0]  qu_s3 [3], qv_s3 [3];
	logic signed [SW-1:0]     du_s4, dv_s4;
	logic signed [2*CW-1:0]   usq [3], vsq [3];
	logic signed [UUW-1:0]    uu_q, vv_q;
	logic                     in_bounds;
	logic                     hit_s5;
	logic [CW-1:0]            dist_s5;
	logic [2:0][CW-1:0]       pt_s5;

	function automatic logic [CW-1:0] sat_coord(input logic signed [PTW-1:0] x);
		if (x > SMAX)
			return CW'(SMAX);
		else if (x < SMIN)
			return CW'(SMIN);
		else
			return CW'(x);
	endfunction

	// advance while the output register is free or being emptied
	assign en    = !res.valid || res.ready;
	assign q_pop = en && !q_empty;

	rrlh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (!q_empty),
		.num      (q_data.num),
		.den      (q_data.den),
		.in_tag   ('{ok: q_data.ok, o: q_data.o, d: q_data.d}),
		.out_valid(dv_valid),
		.quo      (dv_quo),
		.out_tag  (dv_tag)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			usq[i] = $signed(cfg.u[i]) * $signed(cfg.u[i]);
			vsq[i] = $signed(cfg.v[i]) * $signed(cfg.v[i]);
			p_c[i] = PTW'($signed(o_s1[i])) + PTW'(prod_s1[i] >>> FB);
		end
	end

	assign in_bounds = (du_s4 >= -SW'(uu_q)) && (du_s4 <= SW'(uu_q)) &&
		(dv_s4 >= -SW'(vv_q)) && (dv_s4 <= SW'(vv_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= dv_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		uu_q <= UUW'(usq[0]) + UUW'(usq[1]) + UUW'(usq[2]);
		vv_q <= UUW'(vsq[0]) + UUW'(vsq[1]) + UUW'(vsq[2]);
		if (en) begin
			// drop crossings beyond the cap
			ok_s1 <= dv_tag.ok && (dv_quo <= T_CAP);
			t_s1  <= dv_quo[TW-1:0];
			o_s1  <= dv_tag.o;
			for (int i = 0; i < 3; i++)
				prod_s1[i] <= $signed(dv_tag.d[i]) * $signed({1'b0, dv_quo[TW-1:0]});
			ok_s2 <= ok_s1;
			t_s2  <= t_s1;
			for (int i = 0; i < 3; i++) begin
				p_s2[i] <= p_c[i];
				q_s2[i] <= QW'(p_c[i]) - QW'($signed(cfg.c[i]));
			end
			ok_s3 <= ok_s2;
			t_s3  <= t_s2;
			for (int i = 0; i < 3; i++) begin
				p_s3[i]  <= p_s2[i];
				qu_s3[i] <= q_s2[i] * $signed(cfg.u[i]);
				qv_s3[i] <= q_s2[i] * $signed(cfg.v[i]);
			end
			ok_s4 <= ok_s3;
			t_s4  <= t_s3;
			p_s4  <= p_s3;
			du_s4 <= SW'(qu_s3[0]) + SW'(qu_s3[1]) + SW'(qu_s3[2]);
			dv_s4 <= SW'(qv_s3[0]) + SW'(qv_s3[1]) + SW'(qv_s3[2]);
			hit_s5 <= ok_s4 && in_bounds;
			if (ok_s4 && in_bounds) begin
				dist_s5 <= (t_s4 > TW'({CW{1'b1}})) ? {CW{1'b1}} : t_s4[CW-1:0];
				for (int i = 0; i < 3; i++)
					pt_s5[i] <= sat_coord(p_s4[i]);
			end else begin
				dist_s5 <= '0;
				pt_s5   <= '0;
			end
		end
	end

	assign res.valid      = v_s5;
	assign res.hit        = hit_s5;
	assign res.distance_t = dist_s5;
	assign res.hit_x      = $signed(pt_s5[0]);
	assign res.hit_y      = $signed(pt_s5[1]);
	assign res.hit_z      = $signed(pt_s5[2]);
endmodule

FILE: hw/rtl/ray_rectangle_light_hit.sv
// Top level of the ray versus rectangular area light test.
// Depends on rrlh_pkg, both channel interfaces, rrlh_front, rrlh_fifo, rrlh_back.
`include "ray_rectangle_light_hit_assert.svh"

// Tests each incoming ray (origin and direction, signed Q11.8) against a
// one-sided rectangular area light described by centre, normal and two
// half-edge vectors in the APB registers, and returns one result per ray:
// hit flag, distance t (unsigned Q12.8, saturated) and hit point (signed
// Q11.8, saturated); every miss returns zeros. A new ray is taken every
// cycle unless a full queue holds the front. From ray to result, the front
// registers form the plane dot products, the entry passes through the 4-deep
// queue, the divider (an input register, then one quotient bit per stage)
// finds t, and the back end builds the hit point, the edge projections and
// the output register. A stalled result holds the back end; the queue and
// the front keep taking rays until the queue fills. Registers: light kind at
// byte 0x00, centre 0x08, normal 0x10, edge u 0x18, edge v 0x20, each packed
// x in the low 20 bits, then y, then z. Write registers only when no ray is
// in flight; the edge lengths settle in the cycle after a write.
module ray_rectangle_light_hit import rrlh_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [AW-1:0] paddr,
	input  logic [RW-1:0] pwdata,
	output logic [RW-1:0] prdata,
	output logic          pready,
	rrlh_ray_if.sink      ray,
	rrlh_hit_if.source    res
);
	logic [1:0]      kind_q;
	logic [3*CW-1:0] center_q, normal_q, edge_u_q, edge_v_q;
	logic [RIW-1:0]  reg_idx;
	logic            wr_en;
	lcfg_t           cfg;
	logic            q_push, q_pop, q_full, q_empty;
	qent_t           q_wdata, q_rdata;

	assign pready  = 1'b1;
	assign reg_idx = paddr[AW-1:3];
	assign wr_en   = psel && penable && pwrite && pready;

	// register write; unknown indices are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= '0;
			center_q <= '0;
			normal_q <= '0;
			edge_u_q <= '0;
			edge_v_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_KIND:   kind_q   <= pwdata[1:0];
				REG_CENTER: center_q <= pwdata[3*CW-1:0];
				REG_NORMAL: normal_q <= pwdata[3*CW-1:0];
				REG_EDGE_U: edge_u_q <= pwdata[3*CW-1:0];
				REG_EDGE_V: edge_v_q <= pwdata[3*CW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_KIND:   prdata = RW'(kind_q);
			REG_CENTER: prdata = RW'(center_q);
			REG_NORMAL: prdata = RW'(normal_q);
			REG_EDGE_U: prdata = RW'(edge_u_q);
			REG_EDGE_V: prdata = RW'(edge_v_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg = '{kind: kind_q, c: center_q, n: normal_q, u: edge_u_q, v: edge_v_q};

	rrlh_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.ray   (ray),
		.cfg   (cfg),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(q_wdata)
	);

	rrlh_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	rrlh_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.q_empty(q_empty),
		.q_data (q_rdata),
		.q_pop  (q_pop),
		.res    (res)
	);

	// a miss carries zero fields
	`RRLH_ASSERT_IMPL(a_miss_zero, res.valid && !res.hit, res.distance_t == '0 && res.hit_x == '0 && res.hit_y == '0 && res.hit_z == '0)
	// the back end never drains an empty queue
	`RRLH_ASSERT_IMPL(a_pop_nonempty, q_pop, !q_empty)
	// a request pushed without a pop is visible the next cycle
	`RRLH_ASSERT_NEXT(a_push_lands, q_push && !q_pop, !q_empty)
endmodule

FILE: bench/tb_ray_rectangle_light_hit.sv
// Self-checking bench for ray_rectangle_light_hit: directed table, then random rays.
// Depends on rrlh_pkg, rrlh_ray_if, rrlh_hit_if and the RTL top level.
module tb_ray_rectangle_light_hit import rrlh_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  CYCLE_LIMIT = 400000;
	localparam int  DRAIN       = 45;        // latency of an empty pipe plus margin
	localparam longint SMAX     = (64'sd1 <<< (CW - 1)) - 1;
	localparam longint SMIN     = -(64'sd1 <<< (CW - 1));
	localparam longint T_CAP    = 64'sd1 <<< (CW + FB);
	localparam longint T_MAX    = (64'sd1 <<< CW) - 1;

	typedef struct packed {
		vec3_t o;
		vec3_t d;
	} ray_t;

	typedef struct packed {
		logic          hit;
		logic [CW-1:0] t;
		vec3_t         p;
	} hit_t;

	typedef struct {
		logic [1:0] kind;
		longint     c[3];
		longint     n[3];
		longint     u[3];
		longint     v[3];
	} light_t;

	typedef struct {
		int   scene;   // index into the directed scene list
		bit   typed;   // expected result written in by hand
		ray_t r;
		hit_t e;
	} row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [AW-1:0] paddr;
	logic [RW-1:0] pwdata;
	logic [RW-1:0] prdata;
	logic pready;

	rrlh_ray_if ray_ch();
	rrlh_hit_if res_ch();

	ray_rectangle_light_hit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.ray    (ray_ch),
		.res    (res_ch)
	);

	// Shadow of the light registers as the block holds them
	light_t lamp;
	hit_t   pending_hits[$];
	hit_t   typed_hits[$];
	bit     typed_flags[$];
	int     errors;
	int     cycles;
	int     src_idle, snk_idle;
	row_t   dir_tab[$];
	light_t scenes[$];

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Give up on a hung pipe
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic longint sat_coord(longint x);
		if (x > SMAX) return SMAX;
		if (x < SMIN) return SMIN;
		return x;
	endfunction

	// Plane crossing, then inclusive containment on the unsaturated point; zeros on any miss
	function automatic hit_t light_crossing(ray_t r);
		longint o[3], d[3], p[3];
		longint plane, den, t, du, dv, uu, vv;
		hit_t   h;
		h = '0;
		if (lamp.kind != LIGHT_AREA) return h;
		plane = 0;
		den   = 0;
		for (int i = 0; i < 3; i++) begin
			o[i]  = longint'($signed(r.o[i]));
			d[i]  = longint'($signed(r.d[i]));
			plane += (o[i] - lamp.c[i]) * lamp.n[i];
			den   -= d[i] * lamp.n[i];
		end
		if (den <= 0 || plane < 0) return h;
		t = (plane <<< FB) / den;
		if (t > T_CAP) return h;
		du = 0; dv = 0; uu = 0; vv = 0;
		for (int i = 0; i < 3; i++) begin
			p[i] = o[i] + ((d[i] * t) >>> FB);
			du  += (p[i] - lamp.c[i]) * lamp.u[i];
			dv  += (p[i] - lamp.c[i]) * lamp.v[i];
			uu  += lamp.u[i] * lamp.u[i];
			vv  += lamp.v[i] * lamp.v[i];
		end
		if (du < -uu || du > uu || dv < -vv || dv > vv) return h;
		h.hit = 1'b1;
		h.t   = (t > T_MAX) ? CW'(T_MAX) : CW'(t);
		for (int i = 0; i < 3; i++)
			h.p[i] = CW'(sat_coord(p[i]));
		return h;
	endfunction

	function automatic vec3_t pack3(longint a[3]);
		vec3_t w;
		for (int i = 0; i < 3; i++)
			w[i] = a[i][CW-1:0];
		return w;
	endfunction

	function automatic ray_t mk_ray(longint ox, oy, oz, dx, dy, dz);
		ray_t r;
		r.o[0] = ox[CW-1:0]; r.o[1] = oy[CW-1:0]; r.o[2] = oz[CW-1:0];
		r.d[0] = dx[CW-1:0]; r.d[1] = dy[CW-1:0]; r.d[2] = dz[CW-1:0];
		return r;
	endfunction

	function automatic hit_t mk_hit(logic h, longint t, longint x, longint y, longint z);
		hit_t e;
		e.hit = h;
		e.t = t[CW-1:0];
		e.p[0] = x[CW-1:0]; e.p[1] = y[CW-1:0]; e.p[2] = z[CW-1:0];
		return e;
	endfunction

	function automatic light_t mk_light(logic [1:0] k, longint c[3], longint n[3],
			longint u[3], longint v[3]);
		light_t l;
		l.kind = k;
		l.c = c; l.n = n; l.u = u; l.v = v;
		return l;
	endfunction

	// Two-phase APB write; the register takes the data on the access edge
	task automatic write_reg(logic [RIW-1:0] idx, logic [RW-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Load a whole light; junk in the bits above each register is dropped by the block
	task automatic load_light(light_t l);
		vec3_t pc, pn, pu, pv;
		pc = pack3(l.c);
		pn = pack3(l.n);
		pu = pack3(l.u);
		pv = pack3(l.v);
		write_reg(REG_KIND,   {62'($urandom()) << 2, l.kind});
		write_reg(REG_CENTER, {4'($urandom()), pc});
		write_reg(REG_NORMAL, {4'($urandom()), pn});
		write_reg(REG_EDGE_U, {4'($urandom()), pu});
		write_reg(REG_EDGE_V, {4'($urandom()), pv});
		lamp = l;
		for (int i = 0; i < 3; i++) begin
			lamp.c[i] = longint'($signed(pc[i]));
			lamp.n[i] = longint'($signed(pn[i]));
			lamp.u[i] = longint'($signed(pu[i]));
			lamp.v[i] = longint'($signed(pv[i]));
		end
	endtask

	// Drop the request line, hold until every request has come back, then let the pipe drain
	task automatic settle();
		ray_ch.valid <= 1'b0;
		while (pending_hits.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	// Offer one request, idling first at the sender's rate; hold it until taken
	task automatic send_ray(ray_t r, bit typed, hit_t e);
		while ($urandom_range(99) < src_idle) begin
			ray_ch.valid <= 1'b0;
			@(negedge clk);
		end
		ray_ch.valid    <= 1'b1;
		ray_ch.origin_x <= r.o[0];
		ray_ch.origin_y <= r.o[1];
		ray_ch.origin_z <= r.o[2];
		ray_ch.dir_x    <= r.d[0];
		ray_ch.dir_y    <= r.d[1];
		ray_ch.dir_z    <= r.d[2];
		typed_flags.push_back(typed);
		typed_hits.push_back(e);
		do @(posedge clk); while (!ray_ch.ready);
		@(negedge clk);
	endtask

	// Predict on acceptance; a typed row overrides the predictor's answer
	always @(posedge clk) begin
		hit_t e;
		ray_t r;
		if (arst_n && ray_ch.valid && ray_ch.ready) begin
			r.o[0] = ray_ch.origin_x; r.o[1] = ray_ch.origin_y; r.o[2] = ray_ch.origin_z;
			r.d[0] = ray_ch.dir_x;    r.d[1] = ray_ch.dir_y;    r.d[2] = ray_ch.dir_z;
			e = light_crossing(r);
			if (typed_flags.size() != 0 && typed_flags[0])
				e = typed_hits[0];
			if (typed_flags.size() != 0) begin
				void'(typed_flags.pop_front());
				void'(typed_hits.pop_front());
			end
			pending_hits.push_back(e);
		end
	end

	// Compare every accepted result with the oldest expectation
	always @(posedge clk) begin
		hit_t e, a;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			a.hit = res_ch.hit;
			a.t   = res_ch.distance_t;
			a.p[0] = res_ch.hit_x; a.p[1] = res_ch.hit_y; a.p[2] = res_ch.hit_z;
			if (pending_hits.size() == 0) begin
				errors++;
				$display("%0t: unexpected result hit=%0b t=%0d p=(%0d,%0d,%0d)", $time,
					a.hit, a.t, $signed(a.p[0]), $signed(a.p[1]), $signed(a.p[2]));
			end else begin
				e = pending_hits.pop_front();
				if (e != a) begin
					errors++;
					$display("%0t: expected hit=%0b t=%0d p=(%0d,%0d,%0d) got hit=%0b t=%0d p=(%0d,%0d,%0d)",
						$time, e.hit, e.t, $signed(e.p[0]), $signed(e.p[1]), $signed(e.p[2]),
						a.hit, a.t, $signed(a.p[0]), $signed(a.p[1]), $signed(a.p[2]));
				end
			end
		end
	end

	// Receiver backpressure at its current rate
	always @(negedge clk)
		res_ch.ready <= ($urandom_range(99) >= snk_idle);

	// Random rectangle: normal from the edge cross product, scaled into a small range
	function automatic light_t random_light();
		longint c[3], n[3], u[3], v[3];
		longint big;
		for (int i = 0; i < 3; i++) begin
			c[i] = longint'($urandom_range(120000)) - 60000;
			u[i] = longint'($urandom_range(6000)) - 3000;
			v[i] = longint'($urandom_range(6000)) - 3000;
		end
		if ($urandom_range(9) == 0) u = '{0, 0, 0};
		n[0] = u[1] * v[2] - u[2] * v[1];
		n[1] = u[2] * v[0] - u[0] * v[2];
		n[2] = u[0] * v[1] - u[1] * v[0];
		big = 1024;
		while (big > 511) begin
			big = 0;
			for (int i = 0; i < 3; i++)
				if ((n[i] < 0 ? -n[i] : n[i]) > big) big = (n[i] < 0 ? -n[i] : n[i]);
			if (big > 511)
				for (int i = 0; i < 3; i++) n[i] = n[i] >>> 1;
		end
		if (n[0] == 0 && n[1] == 0 && n[2] == 0) n[2] = 256;
		return mk_light(LIGHT_AREA, c, n, u, v);
	endfunction

	// Mostly rays aimed at the rectangle from the front; the rest fully random
	function automatic ray_t random_ray();
		longint tgt[3], d[3], o[3];
		longint a, b, s, dn;
		ray_t   r;
		if ($urandom_range(99) < 25) begin
			r = ray_t'({$urandom(), $urandom(), $urandom(), $urandom()});
			return r;
		end
		a  = longint'($urandom_range(600)) - 300;
		b  = longint'($urandom_range(600)) - 300;
		s  = longint'($urandom_range(1500));
		dn = 0;
		for (int i = 0; i < 3; i++) begin
			tgt[i] = lamp.c[i] + ((a * lamp.u[i] + b * lamp.v[i]) >>> FB);
			d[i]   = longint'($urandom_range(1200)) - 600;
			dn    += d[i] * lamp.n[i];
		end
		if (dn > 0)
			for (int i = 0; i < 3; i++) d[i] = -d[i];
		for (int i = 0; i < 3; i++)
			o[i] = tgt[i] - ((d[i] * s) >>> FB);
		return mk_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
	endfunction

	initial begin
		light_t cur;
		row_t   row;
		int     scene;
		hit_t   nil;
		longint zc[3], ax_n[3], ax_u[3], ax_v[3], far_c[3], far_n[3], ones[3];

		errors = 0;
		cycles = 0;
		src_idle = 26;
		snk_idle = 88;
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		ray_ch.valid    = 1'b0;
		ray_ch.origin_x = '0; ray_ch.origin_y = '0; ray_ch.origin_z = '0;
		ray_ch.dir_x    = '0; ray_ch.dir_y    = '0; ray_ch.dir_z    = '0;
		res_ch.ready    = 1'b0;
		nil = '0;

		// Directed scenes: reset state, a unit-ish square on z=0, the same square
		// as other light kinds, a far corner with zero edges, all-ones registers
		zc    = '{0, 0, 0};
		ax_n  = '{0, 0, 256};
		ax_u  = '{1024, 0, 0};
		ax_v  = '{0, 1024, 0};
		far_c = '{SMIN, SMIN, SMIN};
		far_n = '{256, 256, 256};
		ones  = '{-1, -1, -1};
		scenes.push_back(mk_light(2'd0, zc, zc, zc, zc));
		scenes.push_back(mk_light(LIGHT_AREA, zc, ax_n, ax_u, ax_v));
		scenes.push_back(mk_light(2'd3, zc, ax_n, ax_u, ax_v));
		scenes.push_back(mk_light(2'd1, zc, ax_n, ax_u, ax_v));
		scenes.push_back(mk_light(2'd0, zc, ax_n, ax_u, ax_v));
		scenes.push_back(mk_light(LIGHT_AREA, far_c, far_n, zc, zc));
		scenes.push_back(mk_light(LIGHT_AREA, ones, ones, ones, ones));

		// Reset state: no light, every ray misses
		dir_tab.push_back('{0, 1, mk_ray(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX), nil});
		dir_tab.push_back('{0, 1, mk_ray(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN), nil});
		// Square on z=0, facing +z
		dir_tab.push_back('{1, 1, mk_ray(0, 0, 2560, 0, 0, -256), mk_hit(1, 2560, 0, 0, 0)});
		dir_tab.push_back('{1, 1, mk_ray(1024, 0, 2560, 0, 0, -256),
			mk_hit(1, 2560, 1024, 0, 0)});                          // on the edge bound
		dir_tab.push_back('{1, 1, mk_ray(1025, 0, 2560, 0, 0, -256), nil}); // just outside
		dir_tab.push_back('{1, 1, mk_ray(0, -1024, 2560, 0, 0, -256),
			mk_hit(1, 2560, 0, -1024, 0)});
		dir_tab.push_back('{1, 1, mk_ray(0, 0, 2560, 256, 0, 0), nil});     // parallel
		dir_tab.push_back('{1, 1, mk_ray(0, 0, 2560, 0, 0, 256), nil});     // back face
		dir_tab.push_back('{1, 1, mk_ray(0, 0, -2560, 0, 0, -256), nil});   // plane behind
		dir_tab.push_back('{1, 1, mk_ray(0, 0, 0, 0, 0, -256), mk_hit(1, 0, 0, 0, 0)});
		dir_tab.push_back('{1, 0, mk_ray(0, 0, 2560, 256, 0, -256), nil});
		dir_tab.push_back('{1, 0, mk_ray(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN), nil});
		dir_tab.push_back('{1, 0, mk_ray(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX), nil});
		dir_tab.push_back('{1, 0, mk_ray(100, 200, SMAX, 0, 0, -1), nil});
		// Same square as non-area lights: always a miss
		dir_tab.push_back('{2, 1, mk_ray(0, 0, 2560, 0, 0, -256), nil});
		dir_tab.push_back('{3, 1, mk_ray(0, 0, 2560, 0, 0, -256), nil});
		dir_tab.push_back('{4, 1, mk_ray(0, 0, 2560, 0, 0, -256), nil});
		// Far corner, degenerate edges: crossing past the cap, and saturated outputs
		dir_tab.push_back('{5, 0, mk_ray(SMAX, SMAX, SMAX, -1, 0, 0), nil});
		dir_tab.push_back('{5, 0, mk_ray(SMAX, SMAX, SMAX, -256, -256, -256), nil});
		dir_tab.push_back('{5, 0, mk_ray(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN), nil});
		dir_tab.push_back('{5, 0, mk_ray(0, 0, 0, -1, -1, -1), nil});
		// All-ones registers
		dir_tab.push_back('{6, 0, mk_ray(SMIN, SMIN, SMIN, 1, 1, 1), nil});
		dir_tab.push_back('{6, 0, mk_ray(-5, -5, -5, 3, 0, 0), nil});

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		lamp = scenes[0];

		// Walk the table; reload the light whenever the scene changes
		scene = 0;
		foreach (dir_tab[k]) begin
			row = dir_tab[k];
			if (row.scene != scene) begin
				settle();
				load_light(scenes[row.scene]);
				scene = row.scene;
			end
			send_ray(row.r, row.typed, row.e);
		end
		settle();

		// Random part: three idling regimes, several lights each
		for (int regime = 0; regime < 3; regime++) begin
			src_idle = (regime == 0) ? 26 : (regime == 1) ? 88 : 0;
			snk_idle = (regime == 0) ? 88 : (regime == 1) ? 26 : 0;
			for (int sc = 0; sc < 5; sc++) begin
				cur = random_light();
				if (sc == 4) begin
					// a non-area kind, including the unused code
					case ($urandom_range(2))
						0: cur.kind = 2'd0;
						1: cur.kind = 2'd1;
						default: cur.kind = 2'd3;
					endcase
				end
				load_light(cur);
				for (int k = 0; k < ((sc == 4) ? 15 : 115); k++)
					send_ray(random_ray(), 1'b0, nil);
				settle();
			end
		end

		if (errors == 0 && typed_flags.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/rrlh_pkg.sv
hw/rtl/rrlh_ray_if.sv
hw/rtl/rrlh_hit_if.sv
hw/rtl/rrlh_front.sv
hw/rtl/rrlh_fifo.sv
hw/rtl/rrlh_div.sv
hw/rtl/rrlh_back.sv
hw/rtl/ray_rectangle_light_hit.sv
bench/tb_ray_rectangle_light_hit.sv
